@@ hw/rtl/relative_pose_delta_core_defines.svh @@
// assertion macros for the relative pose delta core
`ifndef RELATIVE_POSE_DELTA_CORE_DEFINES_SVH
`define RELATIVE_POSE_DELTA_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define RELPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define RELPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/relpd_pkg.sv @@
// shared widths, codes and the arctangent table for the relative pose delta core
package relpd_pkg;

    localparam int ROW_W        = 2;
    localparam int ROT_W        = 18;
    localparam int TRANS_W      = 32;
    localparam int TIME_W       = 48;
    localparam int DTIME_W      = 49;
    localparam int ANGLE_W      = 19;
    localparam int ANG_FRAC     = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_SHIFT = 24;
    localparam int Z_W          = 36;
    localparam int STEP_W       = 5;

    localparam logic signed [Z_W-1:0] PI_Q30 = 36'sd3373259426;

    // row codes
    localparam logic [ROW_W-1:0] ROW_FIRST  = 2'd0;
    localparam logic [ROW_W-1:0] ROW_SECOND = 2'd1;
    localparam logic [ROW_W-1:0] ROW_LAST   = 2'd2;
    localparam logic [ROW_W-1:0] ROW_NONE   = 2'd3;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
    } mac_ctl_t;

    // arctangent of 2^-i in Q.30
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = 36'sd843314857;
            5'd1:    v = 36'sd497837829;
            5'd2:    v = 36'sd263043837;
            5'd3:    v = 36'sd133525159;
            5'd4:    v = 36'sd67021687;
            5'd5:    v = 36'sd33543516;
            5'd6:    v = 36'sd16775851;
            5'd7:    v = 36'sd8388437;
            5'd8:    v = 36'sd4194283;
            5'd9:    v = 36'sd2097149;
            5'd10:   v = 36'sd1048576;
            default: v = Z_W'(1) <<< (STEP_W'(ANG_FRAC) - i);
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/relpd_if.sv @@
// valid/ready channels for pose rows and pose delta results
interface relpd_row_if import relpd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [ROW_W-1:0]          row_index;
    logic signed [ROT_W-1:0]   rot_col0;
    logic signed [ROT_W-1:0]   rot_col1;
    logic signed [ROT_W-1:0]   rot_col2;
    logic signed [TRANS_W-1:0] trans;
    logic [TIME_W-1:0]         pose_time;

    modport source (output valid, row_index, rot_col0, rot_col1, rot_col2, trans, pose_time,
                    input ready);
    modport sink (input valid, row_index, rot_col0, rot_col1, rot_col2, trans, pose_time,
                  output ready);
endinterface

interface relpd_delta_if import relpd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic signed [ANGLE_W-1:0] angle_z;
    logic signed [TRANS_W-1:0] delta_x;
    logic signed [TRANS_W-1:0] delta_y;
    logic signed [TRANS_W-1:0] delta_z;
    logic signed [DTIME_W-1:0] delta_time;
    logic [TIME_W-1:0]         out_time;
    logic                      degenerate;

    modport source (output valid, angle_x, angle_y, angle_z, delta_x, delta_y, delta_z,
                    delta_time, out_time, degenerate, input ready);
    modport sink (input valid, angle_x, angle_y, angle_z, delta_x, delta_y, delta_z,
                  delta_time, out_time, degenerate, output ready);
endinterface

@@ hw/rtl/relative_pose_delta_core.sv @@
// relative pose delta core: top level with sequencer and pose storage
// Input channel pose_row carries one matrix row per item: rows 0 and 1 are
// stored; row 2 completes the pose and starts the computation; row index 3
// is taken and dropped. Output channel pose_delta carries one item per
// completed pose: euler deltas, displacement, time step and time.
// A completed pose runs through one shared multiply-accumulate unit (18 dot
// products of three terms and one sum of two squares), then the bit-serial
// square root and up to three cordic atan2 runs on one shared cordic unit;
// the x and z angles are skipped when the pitch cosine is zero. The first
// pose after reset skips the computation. The input is not ready while
// a pose is worked on.
// The result sits in an output register; while the receiver stalls, rows 0
// and 1 are still taken, and a finished pose waits until the register frees.
// Reset clears the sequencer, the output valid, the last pose time and marks the
// next pose as the first one, which yields zero deltas.
`include "relative_pose_delta_core_defines.svh"

module relative_pose_delta_core import relpd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    relpd_row_if.sink     pose_row,
    relpd_delta_if.source pose_delta
);

    localparam int MR_W  = 2 * ROT_W + 1 - FRAC_BITS;
    localparam int A_W   = (MR_W > ROT_W) ? MR_W : ROT_W;
    localparam int B_W   = TRANS_W;
    localparam int ACC_W = A_W + B_W + 2;
    localparam int RND_W = ACC_W + 1;
    localparam int ARG_W = MR_W + 1;

    localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] S_HI = RND_W'(32'sh7FFF_FFFF);
    localparam logic signed [RND_W-1:0] S_LO = -S_HI - RND_W'(1);

    localparam logic [2:0] PH_ACC = 3'd3;
    localparam logic [2:0] PH_WB  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_SQRT, S_ATY_GO, S_ATY_WAIT, S_ATX_GO, S_ATX_WAIT,
        S_ATZ_GO, S_ATZ_WAIT, S_FINISH
    } state_t;

    typedef enum logic [2:0] {K_MR, K_IP, K_MT, K_D, K_SQ} kind_t;

    function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
        return 4'({r, 1'b0}) + 4'(r) + 4'(c);
    endfunction

    function automatic logic signed [TRANS_W-1:0] sat32(input logic signed [RND_W-1:0] v);
        logic signed [TRANS_W-1:0] r;
        priority if (v > S_HI)
        begin
            r = S_HI[TRANS_W-1:0];
        end
        else if (v < S_LO)
        begin
            r = S_LO[TRANS_W-1:0];
        end
        else
        begin
            r = v[TRANS_W-1:0];
        end
        return r;
    endfunction

    // control state
    state_t             state_reg;
    kind_t              kind_reg;
    logic [1:0]         ia_reg;
    logic [1:0]         ja_reg;
    logic [2:0]         phase_reg;
    logic               first_pose_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic               out_valid_reg;

    // pose and intermediate storage
    logic signed [ROT_W-1:0]   rc_reg [9];
    logic signed [TRANS_W-1:0] tc_reg [3];
    logic signed [ROT_W-1:0]   prev_rot_reg [9];
    logic signed [TRANS_W-1:0] prev_tr_reg [3];
    logic signed [MR_W-1:0]    mr_reg [9];
    logic signed [TRANS_W-1:0] ip_reg [3];
    logic signed [TRANS_W-1:0] mt_reg [3];
    logic signed [TRANS_W-1:0] dl_reg [3];
    logic [MR_W-1:0]           cy_reg;
    logic [TIME_W-1:0]         t_now_reg;
    logic signed [ANGLE_W-1:0] ax_reg;
    logic signed [ANGLE_W-1:0] ay_reg;
    logic signed [ANGLE_W-1:0] az_reg;
    logic                      deg_reg;

    // output register
    logic signed [ANGLE_W-1:0] o_ax_reg;
    logic signed [ANGLE_W-1:0] o_ay_reg;
    logic signed [ANGLE_W-1:0] o_az_reg;
    logic signed [TRANS_W-1:0] o_dx_reg;
    logic signed [TRANS_W-1:0] o_dy_reg;
    logic signed [TRANS_W-1:0] o_dz_reg;
    logic signed [DTIME_W-1:0] o_dt_reg;
    logic [TIME_W-1:0]         o_time_reg;
    logic                      o_deg_reg;

    // datapath wires
    mac_ctl_t                  mac_ctl;
    logic signed [A_W-1:0]     op_a;
    logic signed [B_W-1:0]     op_b;
    logic signed [ACC_W-1:0]   acc;
    logic [1:0]                term;
    logic signed [RND_W-1:0]   acc_ext;
    logic signed [RND_W-1:0]   acc_neg;
    logic signed [RND_W-1:0]   rnd_pos;
    logic signed [RND_W-1:0]   rnd_neg;
    logic signed [RND_W-1:0]   mt_sum;
    logic                      sqrt_start;
    logic [MR_W-1:0]           sqrt_root;
    logic                      sqrt_done;
    logic                      cor_start;
    logic signed [ARG_W-1:0]   cor_y;
    logic signed [ARG_W-1:0]   cor_x;
    logic signed [ANGLE_W-1:0] cor_angle;
    logic                      cor_done;
    logic                      cor_busy;
    logic                      row_acc;
    logic                      wb;
    logic                      finish_load;
    logic                      last_row_acc;
    logic                      deg_out;
    logic                      xz_zero;

    // handshake and phase decode
    always_comb
    begin
        row_acc     = pose_row.valid && pose_row.ready;
        wb          = (state_reg == S_MAC) && (phase_reg == PH_WB);
        finish_load = (state_reg == S_FINISH) && (!out_valid_reg || pose_delta.ready);
        term        = (phase_reg < PH_ACC) ? phase_reg[1:0] : 2'd0;
        mac_ctl.mul_en   = (state_reg == S_MAC) && (phase_reg < PH_ACC);
        mac_ctl.acc_load = (state_reg == S_MAC) && (phase_reg == 3'd1);
        mac_ctl.acc_add  = (state_reg == S_MAC) && ((phase_reg == 3'd2) || (phase_reg == 3'd3));
        sqrt_start  = wb && (kind_reg == K_SQ);
        cor_start   = (state_reg == S_ATY_GO) || (state_reg == S_ATX_GO) ||
                      (state_reg == S_ATZ_GO);
        last_row_acc = row_acc && (pose_row.row_index == ROW_LAST);
        deg_out      = pose_delta.valid && pose_delta.degenerate;
        xz_zero      = (pose_delta.angle_x == '0) && (pose_delta.angle_z == '0);
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (kind_reg)
            K_MR:
            begin
                op_a = A_W'(rc_reg[idx3(ia_reg, term)]);
                op_b = B_W'(prev_rot_reg[idx3(ja_reg, term)]);
            end
            K_IP:
            begin
                op_a = A_W'(prev_rot_reg[idx3(term, ja_reg)]);
                op_b = prev_tr_reg[term];
            end
            K_MT:
            begin
                op_a = A_W'(rc_reg[idx3(ja_reg, term)]);
                op_b = ip_reg[term];
            end
            K_D:
            begin
                op_a = A_W'(mr_reg[idx3(term, ja_reg)]);
                op_b = mt_reg[term];
            end
            K_SQ:
            begin
                if (term == 2'd0)
                begin
                    op_a = A_W'(mr_reg[7]);
                    op_b = B_W'(mr_reg[7]);
                end
                else if (term == 2'd1)
                begin
                    op_a = A_W'(mr_reg[8]);
                    op_b = B_W'(mr_reg[8]);
                end
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // rounding of the accumulated sum
    always_comb
    begin
        acc_ext = RND_W'(acc);
        acc_neg = -acc_ext;
        rnd_pos = (acc_ext + HALF) >>> FRAC_BITS;
        rnd_neg = (acc_neg + HALF) >>> FRAC_BITS;
        mt_sum  = rnd_pos + RND_W'(tc_reg[ja_reg]);
    end

    // cordic arguments per angle
    always_comb
    begin
        unique case (state_reg)
            S_ATX_GO:
            begin
                cor_y = -ARG_W'(mr_reg[7]);
                cor_x = ARG_W'(mr_reg[8]);
            end
            S_ATZ_GO:
            begin
                cor_y = -ARG_W'(mr_reg[3]);
                cor_x = ARG_W'(mr_reg[0]);
            end
            default:
            begin
                cor_y = ARG_W'(mr_reg[6]);
                cor_x = ARG_W'({1'b0, cy_reg});
            end
        endcase
    end

    relpd_mac #(
        .A_W   (A_W),
        .B_W   (B_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    relpd_sqrt #(
        .ROOT_W (MR_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc[2*MR_W-1:0]),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    relpd_cordic #(
        .ARG_W     (ARG_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .arg_y (cor_y),
        .arg_x (cor_x),
        .angle (cor_angle),
        .done  (cor_done),
        .busy  (cor_busy)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= K_MR;
            ia_reg         <= '0;
            ja_reg         <= '0;
            phase_reg      <= '0;
            first_pose_reg <= 1'b1;
            last_time_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (finish_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pose_delta.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (row_acc && (pose_row.row_index == ROW_LAST))
                    begin
                        kind_reg  <= K_MR;
                        ia_reg    <= '0;
                        ja_reg    <= '0;
                        phase_reg <= '0;
                        state_reg <= first_pose_reg ? S_FINISH : S_MAC;
                    end
                end
                S_MAC:
                begin
                    if (phase_reg != PH_WB)
                    begin
                        phase_reg <= phase_reg + 1'b1;
                    end
                    else
                    begin
                        phase_reg <= '0;
                        unique case (kind_reg)
                            K_MR:
                            begin
                                if (ja_reg == 2'd2)
                                begin
                                    ja_reg <= '0;
                                    if (ia_reg == 2'd2)
                                    begin
                                        ia_reg   <= '0;
                                        kind_reg <= K_IP;
                                    end
                                    else
                                    begin
                                        ia_reg <= ia_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    ja_reg <= ja_reg + 1'b1;
                                end
                            end
                            K_IP, K_MT, K_D:
                            begin
                                if (ja_reg == 2'd2)
                                begin
                                    ja_reg <= '0;
                                    priority if (kind_reg == K_IP)
                                    begin
                                        kind_reg <= K_MT;
                                    end
                                    else if (kind_reg == K_MT)
                                    begin
                                        kind_reg <= K_D;
                                    end
                                    else
                                    begin
                                        kind_reg <= K_SQ;
                                    end
                                end
                                else
                                begin
                                    ja_reg <= ja_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_SQRT;
                            end
                        endcase
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= S_ATY_GO;
                    end
                end
                S_ATY_GO:
                begin
                    state_reg <= S_ATY_WAIT;
                end
                S_ATY_WAIT:
                begin
                    if (cor_done)
                    begin
                        state_reg <= (cy_reg == '0) ? S_FINISH : S_ATX_GO;
                    end
                end
                S_ATX_GO:
                begin
                    state_reg <= S_ATX_WAIT;
                end
                S_ATX_WAIT:
                begin
                    if (cor_done)
                    begin
                        state_reg <= S_ATZ_GO;
                    end
                end
                S_ATZ_GO:
                begin
                    state_reg <= S_ATZ_WAIT;
                end
                S_ATZ_WAIT:
                begin
                    if (cor_done)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (finish_load)
                    begin
                        last_time_reg  <= t_now_reg;
                        first_pose_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // pose rows, intermediate values and results
    always_ff @(posedge clk)
    begin
        if (row_acc && (pose_row.row_index != ROW_NONE))
        begin
            rc_reg[idx3(pose_row.row_index, 2'd0)] <= pose_row.rot_col0;
            rc_reg[idx3(pose_row.row_index, 2'd1)] <= pose_row.rot_col1;
            rc_reg[idx3(pose_row.row_index, 2'd2)] <= pose_row.rot_col2;
            tc_reg[pose_row.row_index]             <= pose_row.trans;
            if (pose_row.row_index == ROW_LAST)
            begin
                t_now_reg <= pose_row.pose_time;
                if (first_pose_reg)
                begin
                    ax_reg    <= '0;
                    ay_reg    <= '0;
                    az_reg    <= '0;
                    deg_reg   <= 1'b0;
                    dl_reg[0] <= '0;
                    dl_reg[1] <= '0;
                    dl_reg[2] <= '0;
                end
            end
        end

        if (wb)
        begin
            unique case (kind_reg)
                K_MR:    mr_reg[idx3(ia_reg, ja_reg)] <= rnd_pos[MR_W-1:0];
                K_IP:    ip_reg[ja_reg] <= sat32(rnd_neg);
                K_MT:    mt_reg[ja_reg] <= sat32(mt_sum);
                K_D:     dl_reg[ja_reg] <= sat32(rnd_neg);
                default: ;
            endcase
        end

        if ((state_reg == S_SQRT) && sqrt_done)
        begin
            cy_reg <= sqrt_root;
        end

        if (cor_done)
        begin
            unique case (state_reg)
                S_ATY_WAIT:
                begin
                    ay_reg  <= cor_angle;
                    deg_reg <= cy_reg == '0;
                    ax_reg  <= '0;
                    az_reg  <= '0;
                end
                S_ATX_WAIT: ax_reg <= cor_angle;
                S_ATZ_WAIT: az_reg <= cor_angle;
                default: ;
            endcase
        end

        if (finish_load)
        begin
            o_ax_reg     <= ax_reg;
            o_ay_reg     <= ay_reg;
            o_az_reg     <= az_reg;
            o_dx_reg     <= dl_reg[0];
            o_dy_reg     <= dl_reg[1];
            o_dz_reg     <= dl_reg[2];
            o_dt_reg     <= DTIME_W'(t_now_reg) - DTIME_W'(last_time_reg);
            o_time_reg   <= t_now_reg;
            o_deg_reg    <= deg_reg;
            prev_rot_reg <= rc_reg;
            prev_tr_reg  <= tc_reg;
        end
    end

    // channel outputs
    assign pose_row.ready        = state_reg == S_IDLE;
    assign pose_delta.valid      = out_valid_reg;
    assign pose_delta.angle_x    = o_ax_reg;
    assign pose_delta.angle_y    = o_ay_reg;
    assign pose_delta.angle_z    = o_az_reg;
    assign pose_delta.delta_x    = o_dx_reg;
    assign pose_delta.delta_y    = o_dy_reg;
    assign pose_delta.delta_z    = o_dz_reg;
    assign pose_delta.delta_time = o_dt_reg;
    assign pose_delta.out_time   = o_time_reg;
    assign pose_delta.degenerate = o_deg_reg;

    // checks
    `RELPD_ASSERT_NEXT(a_busy_last, last_row_acc, !pose_row.ready, "input ready after row 2")
    `RELPD_ASSERT_SAME(a_degenerate_zero, deg_out, xz_zero, "degenerate with nonzero angle")
    `RELPD_ASSERT_SAME(a_sqrt_waited, sqrt_done, state_reg == S_SQRT, "square root done early")
    `RELPD_ASSERT_SAME(a_cordic_free, cor_start, !cor_busy, "cordic started while busy")

endmodule

@@ hw/rtl/relpd_mac.sv @@
// shared multiplier with registered product and accumulator
module relpd_mac import relpd_pkg::*; #(
    parameter int A_W   = 21,
    parameter int B_W   = 32,
    parameter int ACC_W = 55
) (
    input  logic                    clk,
    input  mac_ctl_t                ctl,
    input  logic signed [A_W-1:0]   op_a,
    input  logic signed [B_W-1:0]   op_b,
    output logic signed [ACC_W-1:0] acc
);

    localparam int P_W = A_W + B_W;

    logic signed [P_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // product stage then accumulate stage
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= P_W'(op_a) * P_W'(op_b);
        end
        priority if (ctl.acc_load)
        begin
            acc_reg <= ACC_W'(prod_reg);
        end
        else if (ctl.acc_add)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        else
        begin
            acc_reg <= acc_reg;
        end
    end

    assign acc = acc_reg;

endmodule

@@ hw/rtl/relpd_sqrt.sv @@
// bit-serial floor square root, one result bit per cycle
module relpd_sqrt import relpd_pkg::*; #(
    parameter int ROOT_W = 21
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic [ROOT_W-1:0]     root,
    output logic                  done
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // bring in the next two radicand bits and try the next root bit
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = REM_W'({root_reg, 2'b01});
        fits      = rem_shift >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rad_reg <= rad_reg << 2;
                if (fits)
                begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

@@ hw/rtl/relpd_cordic.sv @@
// vectoring cordic atan2, one rotation per cycle, rounded and saturated angle
module relpd_cordic import relpd_pkg::*; #(
    parameter int ARG_W     = 22,
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [ARG_W-1:0]   arg_y,
    input  logic signed [ARG_W-1:0]   arg_x,
    output logic signed [ANGLE_W-1:0] angle,
    output logic                      done,
    output logic                      busy
);

    localparam int CW  = ARG_W + CORDIC_SHIFT + 3;
    localparam int RSH = ANG_FRAC - FRAC_BITS;
    localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(1) <<< (RSH - 1);
    localparam logic signed [Z_W-1:0] ANG_HI = Z_W'((1 <<< (ANGLE_W - 1)) - 1);
    localparam logic signed [Z_W-1:0] ANG_LO = Z_W'(-(1 <<< (ANGLE_W - 1)));

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_ROUND} cstate_t;

    cstate_t                   cst_reg;
    logic [STEP_W-1:0]         step_reg;
    logic signed [CW-1:0]      x_reg;
    logic signed [CW-1:0]      y_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic                      done_reg;

    logic signed [CW-1:0]      xs;
    logic signed [CW-1:0]      ys;
    logic signed [CW-1:0]      dx;
    logic signed [CW-1:0]      dy;
    logic signed [Z_W-1:0]     z_rnd;
    logic                      y_pos;

    // scaled inputs, shifted terms and final rounding
    always_comb
    begin
        xs    = CW'(arg_x) <<< CORDIC_SHIFT;
        ys    = CW'(arg_y) <<< CORDIC_SHIFT;
        dx    = y_reg >>> step_reg;
        dy    = x_reg >>> step_reg;
        y_pos = !y_reg[CW-1] && (y_reg != '0);
        z_rnd = (z_reg + Z_HALF) >>> RSH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cst_reg   <= C_IDLE;
            step_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            angle_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (cst_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        step_reg <= '0;
                        if ((arg_x == '0) && (arg_y == '0))
                        begin
                            angle_reg <= '0;
                            done_reg  <= 1'b1;
                        end
                        else if (arg_x[ARG_W-1])
                        begin
                            // pre-rotate into the right half plane
                            x_reg   <= -xs;
                            y_reg   <= -ys;
                            z_reg   <= arg_y[ARG_W-1] ? -PI_Q30 : PI_Q30;
                            cst_reg <= C_RUN;
                        end
                        else
                        begin
                            x_reg   <= xs;
                            y_reg   <= ys;
                            z_reg   <= '0;
                            cst_reg <= C_RUN;
                        end
                    end
                end
                C_RUN:
                begin
                    if (y_pos)
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_q30(step_reg);
                    end
                    else
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_q30(step_reg);
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    begin
                        cst_reg <= C_ROUND;
                    end
                end
                C_ROUND:
                begin
                    priority if (z_rnd > ANG_HI)
                    begin
                        angle_reg <= ANG_HI[ANGLE_W-1:0];
                    end
                    else if (z_rnd < ANG_LO)
                    begin
                        angle_reg <= ANG_LO[ANGLE_W-1:0];
                    end
                    else
                    begin
                        angle_reg <= z_rnd[ANGLE_W-1:0];
                    end
                    done_reg <= 1'b1;
                    cst_reg  <= C_IDLE;
                end
                default:
                begin
                    cst_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign angle = angle_reg;
    assign done  = done_reg;
    assign busy  = cst_reg != C_IDLE;

endmodule

@@ tb/sv/relpd_tb_if.sv @@
// note: the rtl already defines the channel interfaces in hw/rtl/relpd_if.sv; the testbench uses those

@@ tb/sv/relative_pose_delta_core_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the relative pose delta core
module relative_pose_delta_core_test;
    import relpd_pkg::*;

    localparam int FRAC = 16;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] ax;
        logic signed [ANGLE_W-1:0] ay;
        logic signed [ANGLE_W-1:0] az;
        logic signed [TRANS_W-1:0] dx;
        logic signed [TRANS_W-1:0] dy;
        logic signed [TRANS_W-1:0] dz;
        logic signed [DTIME_W-1:0] dt;
        logic [TIME_W-1:0]         tm;
        logic                      deg;
    } delta_t;

    typedef struct packed {
        logic [ROW_W-1:0]          row;
        logic signed [ROT_W-1:0]   c0;
        logic signed [ROT_W-1:0]   c1;
        logic signed [ROT_W-1:0]   c2;
        logic signed [TRANS_W-1:0] tr;
        logic [TIME_W-1:0]         tm;
    } row_t;

    logic clk;
    logic rst_n;
    relpd_row_if   pose_row ();
    relpd_delta_if pose_delta ();

    relative_pose_delta_core #(.FRAC_BITS(FRAC)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pose_row  (pose_row.sink),
        .pose_delta(pose_delta.source)
    );

    // predictor state
    longint prev_rot [9];
    longint prev_tr [3];
    longint pend_rot [6];
    longint pend_tr [2];
    logic [TIME_W-1:0] last_tm;
    bit first_pose;

    delta_t expected_deltas[$];
    int errors;
    int poses_seen;
    int degen_seen;
    bit sink_steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("relative_pose_delta_core test failed");
        $finish;
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd(longint v, int s);
        return asr(v + (64'sd1 << (s - 1)), s);
    endfunction

    function automatic longint sat32(longint v);
        if (v < -64'sd2147483648) return -64'sd2147483648;
        if (v > 64'sd2147483647) return 64'sd2147483647;
        return v;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // cordic vectoring arctangent, q.30 angle rounded to q.16
    function automatic longint arctan2(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        longint a;
        longint r;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 16777216;
        y = y * 16777216;
        if (x < 0)
        begin
            z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = asr(y, i);
            dy = asr(x, i);
            a = longint'(atan_q30(STEP_W'(i)));
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + a;
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - a;
            end
        end
        r = rnd(z, ANG_FRAC - FRAC);
        if (r > 262143) r = 262143;
        if (r < -262144) r = -262144;
        return r;
    endfunction

    // pose delta predictor: returns 1 when the row completes a pose
    function automatic bit predict_delta(row_t it, output delta_t d);
        longint rc [9];
        longint tc [3];
        longint mr [9];
        longint ip [3];
        longint mt [3];
        longint dd [3];
        longint s;
        longint ax;
        longint ay;
        longint az;
        longint a;
        longint b;
        longint cy;
        bit deg;
        d = '0;
        if (it.row == ROW_NONE) return 0;
        if (it.row != ROW_LAST)
        begin
            pend_rot[it.row * 3]     = it.c0;
            pend_rot[it.row * 3 + 1] = it.c1;
            pend_rot[it.row * 3 + 2] = it.c2;
            pend_tr[it.row] = it.tr;
            return 0;
        end
        for (int j = 0; j < 6; j++) rc[j] = pend_rot[j];
        rc[6] = it.c0;
        rc[7] = it.c1;
        rc[8] = it.c2;
        tc[0] = pend_tr[0];
        tc[1] = pend_tr[1];
        tc[2] = it.tr;
        ax = 0;
        ay = 0;
        az = 0;
        deg = 0;
        dd[0] = 0;
        dd[1] = 0;
        dd[2] = 0;
        if (!first_pose)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    s = 0;
                    for (int k = 0; k < 3; k++) s += rc[i * 3 + k] * prev_rot[j * 3 + k];
                    mr[i * 3 + j] = rnd(s, FRAC);
                end
            for (int j = 0; j < 3; j++)
            begin
                s = 0;
                for (int k = 0; k < 3; k++) s += prev_rot[k * 3 + j] * prev_tr[k];
                ip[j] = sat32(rnd(-s, FRAC));
            end
            for (int i = 0; i < 3; i++)
            begin
                s = 0;
                for (int k = 0; k < 3; k++) s += rc[i * 3 + k] * ip[k];
                mt[i] = sat32(rnd(s, FRAC) + tc[i]);
            end
            for (int j = 0; j < 3; j++)
            begin
                s = 0;
                for (int i = 0; i < 3; i++) s += mr[i * 3 + j] * mt[i];
                dd[j] = sat32(rnd(-s, FRAC));
            end
            a = mr[7] < 0 ? -mr[7] : mr[7];
            b = mr[8] < 0 ? -mr[8] : mr[8];
            cy = root_floor(longint'(a * a + b * b));
            ay = arctan2(mr[6], cy);
            if (cy == 0)
                deg = 1;
            else
            begin
                ax = arctan2(-mr[7], mr[8]);
                az = arctan2(-mr[3], mr[0]);
            end
        end
        d.ax = ANGLE_W'(ax);
        d.ay = ANGLE_W'(ay);
        d.az = ANGLE_W'(az);
        d.dx = TRANS_W'(dd[0]);
        d.dy = TRANS_W'(dd[1]);
        d.dz = TRANS_W'(dd[2]);
        d.dt = DTIME_W'({1'b0, it.tm} - {1'b0, last_tm});
        d.tm = it.tm;
        d.deg = deg;
        for (int j = 0; j < 9; j++) prev_rot[j] = rc[j];
        for (int j = 0; j < 3; j++) prev_tr[j] = tc[j];
        last_tm = it.tm;
        first_pose = 0;
        return 1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // stimulus table: the directed rows, with hand-written results where obvious
    row_t   stim_rows[$];
    bit     stim_known[$];
    delta_t stim_want[$];
    bit     sender_stalls;

    task automatic add_row(row_t r);
        stim_rows  = {stim_rows, r};
        stim_known = {stim_known, 1'b0};
        stim_want  = {stim_want, delta_t'('0)};
    endtask

    task automatic add_row_known(row_t r, delta_t w);
        stim_rows  = {stim_rows, r};
        stim_known = {stim_known, 1'b1};
        stim_want  = {stim_want, w};
    endtask

    function automatic row_t make_row(logic [ROW_W-1:0] r, longint c0, longint c1,
                                      longint c2, longint tr, longint unsigned tm);
        row_t x;
        x.row = r;
        x.c0 = ROT_W'(c0);
        x.c1 = ROT_W'(c1);
        x.c2 = ROT_W'(c2);
        x.tr = TRANS_W'(tr);
        x.tm = TIME_W'(tm);
        return x;
    endfunction

    function automatic row_t rand_row(logic [ROW_W-1:0] r, bit wild);
        row_t x;
        x.row = r;
        if (wild)
        begin
            x.c0 = ROT_W'($urandom);
            x.c1 = ROT_W'($urandom);
            x.c2 = ROT_W'($urandom);
            x.tr = $urandom;
        end
        else
        begin
            x.c0 = ROT_W'(int'($urandom_range(131072)) - 65536);
            x.c1 = ROT_W'(int'($urandom_range(131072)) - 65536);
            x.c2 = ROT_W'(int'($urandom_range(131072)) - 65536);
            x.tr = TRANS_W'(int'($urandom_range(2000000)) - 1000000);
        end
        x.tm = TIME_W'({$urandom, $urandom});
        return x;
    endfunction

    // send one item, with random gaps; valid stays up between items unless a gap is drawn
    task automatic send_item(row_t it);
        while (sender_stalls && $urandom_range(99) < 34)
        begin
            pose_row.valid <= 1'b0;
            @(negedge clk);
        end
        pose_row.valid     <= 1'b1;
        pose_row.row_index <= it.row;
        pose_row.rot_col0  <= it.c0;
        pose_row.rot_col1  <= it.c1;
        pose_row.rot_col2  <= it.c2;
        pose_row.trans     <= it.tr;
        pose_row.pose_time <= it.tm;
        do @(posedge clk); while (!pose_row.ready);
        @(negedge clk);
    endtask

    task automatic run_row(row_t it, bit known, delta_t want);
        delta_t d;
        if (predict_delta(it, d))
        begin
            if (known && d != want)
            begin
                errors++;
                $display("predictor disagrees with table at time %0d", it.tm);
            end
            expected_deltas = {expected_deltas, d};
        end
        send_item(it);
    endtask

    // receiver: random stalls, compare against the oldest expectation
    initial
    begin
        delta_t e;
        pose_delta.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pose_delta.ready <= sink_steady ? 1'b1 : ($urandom_range(99) >= 34);
            @(posedge clk);
            if (pose_delta.valid && pose_delta.ready)
            begin
                if (expected_deltas.size() == 0)
                begin
                    errors++;
                    $display("unexpected pose delta item");
                end
                else
                begin
                    e = expected_deltas.pop_front();
                    poses_seen++;
                    if (e.deg) degen_seen++;
                    if (pose_delta.angle_x != e.ax)
                        report_mismatch("angle_x", pose_delta.angle_x, e.ax);
                    if (pose_delta.angle_y != e.ay)
                        report_mismatch("angle_y", pose_delta.angle_y, e.ay);
                    if (pose_delta.angle_z != e.az)
                        report_mismatch("angle_z", pose_delta.angle_z, e.az);
                    if (pose_delta.delta_x != e.dx)
                        report_mismatch("delta_x", pose_delta.delta_x, e.dx);
                    if (pose_delta.delta_y != e.dy)
                        report_mismatch("delta_y", pose_delta.delta_y, e.dy);
                    if (pose_delta.delta_z != e.dz)
                        report_mismatch("delta_z", pose_delta.delta_z, e.dz);
                    if (pose_delta.delta_time != e.dt)
                        report_mismatch("delta_time", pose_delta.delta_time, e.dt);
                    if (pose_delta.out_time != e.tm)
                        report_mismatch("out_time", pose_delta.out_time, e.tm);
                    if (pose_delta.degenerate != e.deg)
                        report_mismatch("degenerate", pose_delta.degenerate, e.deg);
                end
            end
        end
    end

    // main sequence
    initial
    begin
        localparam longint ONE = 65536;
        delta_t w;
        row_t r;
        int k;
        errors = 0;
        poses_seen = 0;
        degen_seen = 0;
        sink_steady = 0;
        sender_stalls = 1;
        first_pose = 1;
        last_tm = '0;
        pose_row.valid = 1'b0;
        pose_row.row_index = '0;
        pose_row.rot_col0 = '0;
        pose_row.rot_col1 = '0;
        pose_row.rot_col2 = '0;
        pose_row.trans = '0;
        pose_row.pose_time = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first pose: zero deltas, time step equals the pose time
        w = '0;
        w.dt = DTIME_W'(48'd1000);
        w.tm = 48'd1000;
        add_row(make_row(ROW_FIRST, ONE, 0, 0, 100, 0));
        add_row(make_row(ROW_SECOND, 0, ONE, 0, -200, 0));
        add_row_known(make_row(ROW_LAST, 0, 0, ONE, 300, 1000), w);
        // ignored row index three
        add_row(make_row(ROW_NONE, -131072, 131071, -1, -2147483648, 48'hFFFFFFFFFFFF));
        // identical pose: all zero deltas
        w = '0;
        w.dt = DTIME_W'(48'd500);
        w.tm = 48'd1500;
        add_row(make_row(ROW_FIRST, ONE, 0, 0, 100, 0));
        add_row(make_row(ROW_SECOND, 0, ONE, 0, -200, 0));
        add_row_known(make_row(ROW_LAST, 0, 0, ONE, 300, 1500), w);
        // zero cosine: last row with zero second and third column
        add_row(make_row(ROW_LAST, ONE, 0, 0, 0, 1400));
        // extremes, rows out of order, time going backwards and to the maximum
        add_row(make_row(ROW_SECOND, 131071, -131072, 131071, 2147483647, 0));
        add_row(make_row(ROW_FIRST, -131072, 131071, -131072, -2147483648, 0));
        add_row(make_row(ROW_LAST, 131071, 131071, -131072, 2147483647, 48'hFFFFFFFFFFFF));
        add_row(make_row(ROW_LAST, -131072, -131072, 131071, -2147483648, 0));
        add_row(make_row(ROW_LAST, 0, 0, 0, 0, 5));
        add_row(make_row(ROW_FIRST, -ONE, 0, 0, 0, 0));
        add_row(make_row(ROW_SECOND, 0, -ONE, 0, 0, 0));
        add_row(make_row(ROW_LAST, 0, 0, ONE, 0, 7));
        add_row(make_row(ROW_LAST, 0, 0, -ONE, 12345, 9));

        for (int i = 0; i < stim_rows.size(); i++)
            run_row(stim_rows[i], stim_known[i], stim_want[i]);
        pose_row.valid <= 1'b0;

        // hold off until every expected item has come
        while (expected_deltas.size() != 0) @(negedge clk);

        // random part: mostly well-formed poses, a steady stretch in the middle
        k = 0;
        while (k < 1400)
        begin
            sink_steady = (k >= 600 && k < 800);
            sender_stalls = !sink_steady;
            if ($urandom_range(9) < 8)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    r = rand_row(ROW_W'(j), $urandom_range(9) == 0);
                    if (j == 2 && $urandom_range(19) == 0)
                    begin
                        r.c1 = '0;
                        r.c2 = '0;
                    end
                    run_row(r, 0, '0);
                end
                k += 3;
            end
            else
            begin
                r = rand_row(ROW_W'($urandom_range(3)), 1);
                run_row(r, 0, '0);
                if (r.row != ROW_NONE) k++;
            end
        end
        pose_row.valid <= 1'b0;
        sink_steady = 0;

        while (expected_deltas.size() != 0) @(negedge clk);
        repeat (300) @(posedge clk);
        $display("covered %0d poses, %0d with zero pitch cosine, under random stalls",
                 poses_seen, degen_seen);
        if (errors == 0)
            $display("relative_pose_delta_core test passed");
        else
            $display("relative_pose_delta_core test failed");
        $finish;
    end
endmodule
